// ----- hdl/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while reset is held
`define S6U_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain condition checked on every rising edge, off while reset is held
`define S6U_CHECK(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- hdl/s6u_pkg.sv -----
// shared types and constants of the six-bit super-block unpacker
`default_nettype none
package s6u_pkg;

	localparam int unsigned SB_BYTES  = 128 + 64 + 16 + 2;
	localparam int unsigned SC_BASE   = 192;
	localparam int unsigned D_BASE    = 208;
	localparam int unsigned N_CHUNKS  = 32;
	localparam int unsigned MEM_WORDS = SC_BASE / 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_LO,
		ST_RD_HI,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic wr;
		logic rd_lo;
		logic rd_hi;
		logic lat_lo;
		logic scale_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_byte;
		logic scale_busy;
		logic last_chunk;
	} status_t;

endpackage
`default_nettype wire

// ----- hdl/s6u_scale.sv -----
// iterative half-precision times signed byte multiplier with rounding
`default_nettype none
module s6u_scale (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] h,
	input  wire logic [7:0]  sc,
	output logic             busy,
	output logic [15:0]      res
);
	logic [4:0]  e;
	logic [9:0]  m;
	logic        sign;
	logic [7:0]  mag;
	logic [10:0] mant;
	logic [18:0] prod;
	logic [17:0] p;
	logic [15:0] spec_res;

	logic        busy_q;
	logic        spec_q;
	logic [15:0] spec_res_q;
	logic        zero_q;
	logic        sign_q;
	logic [4:0]  e_q;
	logic [17:0] p_q;
	logic [17:0] pn_q;
	logic [4:0]  n_q;

	logic signed [6:0] ex;
	logic signed [6:0] x;
	logic signed [6:0] x_adj;
	logic              rnd;
	logic [11:0]       q;
	logic [4:0]        sub_sh;
	logic [17:0]       sub_p;
	logic [6:0]        efield;

	always_comb begin
		e    = h[14:10];
		m    = h[9:0];
		sign = h[15] ^ sc[7];
		mag  = sc[7] ? 8'(-sc) : sc;
		mant = (e == 5'd0) ? {1'b0, m} : {1'b1, m};
		prod = {8'b0, mant} * {11'b0, mag};
		p    = prod[17:0];
		if (m != 10'd0) begin
			spec_res = h | 16'h0200;
		end else if (mag == 8'd0) begin
			spec_res = 16'h7E00;
		end else begin
			spec_res = {sign, 15'h7C00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= (e != 5'd31) && (p != 18'd0);
		end else if (busy_q && pn_q[17]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			spec_q     <= (e == 5'd31);
			spec_res_q <= spec_res;
			zero_q     <= (p == 18'd0);
			sign_q     <= sign;
			e_q        <= e;
			p_q        <= p;
			pn_q       <= p;
			n_q        <= 5'd17;
		end else if (busy_q && !pn_q[17]) begin
			pn_q <= {pn_q[16:0], 1'b0};
			n_q  <= n_q - 5'd1;
		end
	end

	always_comb begin
		ex     = (e_q == 5'd0) ? -7'sd24 : ($signed({2'b0, e_q}) - 7'sd25);
		x      = $signed({2'b0, n_q}) + ex;
		rnd    = pn_q[6] & ((|pn_q[5:0]) | pn_q[7]);
		q      = {1'b0, pn_q[17:7]} + {11'b0, rnd};
		x_adj  = q[11] ? (x + 7'sd1) : x;
		sub_sh = (e_q == 5'd0) ? 5'd0 : (e_q - 5'd1);
		sub_p  = p_q << sub_sh;
		efield = 7'(x_adj + 7'sd15);
		if (spec_q) begin
			res = spec_res_q;
		end else if (zero_q) begin
			res = {sign_q, 15'd0};
		end else if (x < -7'sd14) begin
			res = {sign_q, 5'd0, sub_p[9:0]};
		end else if (x_adj > 7'sd15) begin
			res = {sign_q, 15'h7C00};
		end else begin
			res = {sign_q, efield[4:0], (q[11] ? 10'd0 : q[9:0])};
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

// ----- hdl/s6u_datapath.sv -----
// byte store, chunk counter, weight assembly and result registers
`default_nettype none
module s6u_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire s6u_pkg::cmd_t   cmd,
	output s6u_pkg::status_t     status,
	input  wire logic [7:0]      block_byte,
	input  wire logic            signed_mode,
	output logic                 strobe,
	output logic [7:0]           weight_0,
	output logic [7:0]           weight_1,
	output logic [7:0]           weight_2,
	output logic [7:0]           weight_3,
	output logic [7:0]           weight_4,
	output logic [7:0]           weight_5,
	output logic [7:0]           weight_6,
	output logic [7:0]           weight_7,
	output logic [15:0]          scale_bits,
	output logic [5:0]           zero_point,
	output logic [4:0]           chunk_index,
	output logic                 last_chunk
);
	import s6u_pkg::*;

	logic [7:0][7:0] mem [MEM_WORDS];
	logic [7:0][7:0] rd_data_q;
	logic [7:0][7:0] lo_q;
	logic [7:0]      sc_q [16];
	logic [7:0]      dlo_q;
	logic [7:0]      dhi_q;
	logic [7:0]      cnt_q;
	logic [4:0]      k_q;
	logic [4:0]      rd_addr;

	logic            scale_busy;
	logic [15:0]     scale_res;

	logic [7:0]      w [8];
	logic [5:0]      v [8];
	logic [1:0]      g;
	logic [3:0]      nib;
	logic [1:0]      hb;

	logic            strobe_q;
	logic [7:0]      w_q [8];
	logic [15:0]     scale_q;
	logic [5:0]      zp_q;
	logic [4:0]      idx_q;
	logic            last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 8'd0;
		end else if (cmd.wr) begin
			cnt_q <= (cnt_q == 8'(SB_BYTES - 1)) ? 8'd0 : (cnt_q + 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 5'd0;
		end else if (cmd.wr) begin
			k_q <= 5'd0;
		end else if (cmd.emit) begin
			k_q <= k_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			if (cnt_q < 8'(SC_BASE)) begin
				mem[cnt_q[7:3]][cnt_q[2:0]] <= block_byte;
			end else if (cnt_q < 8'(D_BASE)) begin
				sc_q[cnt_q[3:0]] <= block_byte;
			end else if (cnt_q == 8'(D_BASE)) begin
				dlo_q <= block_byte;
			end else begin
				dhi_q <= block_byte;
			end
		end
	end

	// low-nibble word, then the word of high bits
	always_comb begin
		if (cmd.rd_lo) begin
			rd_addr = {1'b0, k_q[4], k_q[2], k_q[1:0]};
		end else begin
			rd_addr = 5'(16) + {2'b0, k_q[4], k_q[1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_lo || cmd.rd_hi) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.lat_lo) begin
			lo_q <= rd_data_q;
		end
	end

	s6u_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.scale_start),
		.h      ({dhi_q, dlo_q}),
		.sc     (sc_q[k_q[4:1]]),
		.busy   (scale_busy),
		.res    (scale_res)
	);

	always_comb begin
		g   = k_q[3:2];
		nib = 4'd0;
		hb  = 2'd0;
		for (int i = 0; i < 8; i++) begin
			nib  = g[1] ? lo_q[i][7:4] : lo_q[i][3:0];
			hb   = 2'(rd_data_q[i] >> {g, 1'b0});
			v[i] = {hb, nib};
			w[i] = signed_mode ? (8'({2'b0, v[i]}) - 8'd32) : {2'b0, v[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < 8; i++) begin
				w_q[i] <= w[i];
			end
			scale_q <= scale_res;
			zp_q    <= signed_mode ? 6'd0 : 6'd32;
			idx_q   <= k_q;
			last_q  <= (k_q == 5'(N_CHUNKS - 1));
		end
	end

	always_comb begin
		status.last_byte  = (cnt_q == 8'(SB_BYTES - 1));
		status.scale_busy = scale_busy;
		status.last_chunk = (k_q == 5'(N_CHUNKS - 1));
	end

	assign strobe      = strobe_q;
	assign weight_0    = w_q[0];
	assign weight_1    = w_q[1];
	assign weight_2    = w_q[2];
	assign weight_3    = w_q[3];
	assign weight_4    = w_q[4];
	assign weight_5    = w_q[5];
	assign weight_6    = w_q[6];
	assign weight_7    = w_q[7];
	assign scale_bits  = scale_q;
	assign zero_point  = zp_q;
	assign chunk_index = idx_q;
	assign last_chunk  = last_q;

endmodule
`default_nettype wire

// ----- hdl/s6u_ctrl.sv -----
// sequencer for byte intake and chunk emission
`default_nettype none
module s6u_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire s6u_pkg::status_t status,
	output s6u_pkg::cmd_t         cmd,
	output logic                  busy
);
	import s6u_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && status.last_byte) state_d = ST_RD_LO;
			end
			ST_RD_LO: state_d = ST_RD_HI;
			ST_RD_HI: state_d = ST_WAIT;
			ST_WAIT: begin
				if (!status.scale_busy) state_d = status.last_chunk ? ST_IDLE : ST_RD_LO;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				cmd.wr = accept;
			end
			ST_RD_LO: begin
				cmd.rd_lo       = 1'b1;
				cmd.scale_start = 1'b1;
			end
			ST_RD_HI: begin
				cmd.rd_hi  = 1'b1;
				cmd.lat_lo = 1'b1;
			end
			ST_WAIT: begin
				cmd.emit = !status.scale_busy;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/six_bit_superblock_unpack_unit.sv -----
// top level of the six-bit super-block unpacker
`default_nettype none
// six-bit super-block unpacker. a super-block is 210 bytes fed one per cycle
// while busy is low: 128 low-nibble bytes, 64 bytes of two-bit high parts,
// 16 signed sub-scales and the half-precision super scale (little endian).
// after the last byte the unit raises busy and emits 32 results of eight
// weights, one strobe each; the receiver cannot stall, so each result is
// valid for exactly the one strobe cycle. each result takes two reads of the
// single-port byte store (low nibbles, high bits) plus the shift-per-cycle
// normalization of the scale multiplier. signed_mode is a one-bit register on
// its own write channel, always ready; write it only while busy is low.
module six_bit_superblock_unpack_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte intake
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  block_byte,
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	// results
	output logic             strobe,
	output logic [7:0]       weight_0,
	output logic [7:0]       weight_1,
	output logic [7:0]       weight_2,
	output logic [7:0]       weight_3,
	output logic [7:0]       weight_4,
	output logic [7:0]       weight_5,
	output logic [7:0]       weight_6,
	output logic [7:0]       weight_7,
	output logic [15:0]      scale_bits,
	output logic [5:0]       zero_point,
	output logic [4:0]       chunk_index,
	output logic             last_chunk
);
	import s6u_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    ctrl_busy;
	logic    accept;
	logic    signed_mode_q;

	// a byte is taken whenever start is high and the sequencer sits idle
	assign accept    = start && !ctrl_busy;
	assign busy      = ctrl_busy;
	assign cfg_ready = 1'b1;

	// mode register, sampled when each result is built
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			signed_mode_q <= cfg_data;
		end
	end

	s6u_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.status (status),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	// store, weight assembly, scale product and output registers
	s6u_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.block_byte  (block_byte),
		.signed_mode (signed_mode_q),
		.strobe      (strobe),
		.weight_0    (weight_0),
		.weight_1    (weight_1),
		.weight_2    (weight_2),
		.weight_3    (weight_3),
		.weight_4    (weight_4),
		.weight_5    (weight_5),
		.weight_6    (weight_6),
		.weight_7    (weight_7),
		.scale_bits  (scale_bits),
		.zero_point  (zero_point),
		.chunk_index (chunk_index),
		.last_chunk  (last_chunk)
	);

endmodule
`default_nettype wire

// ----- hdl/s6u_checker.sv -----
// port-level checks of the unpacker and their bind
`default_nettype none
`include "assert_macros.svh"
module s6u_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [5:0] zero_point,
	input wire logic [4:0] chunk_index,
	input wire logic       last_chunk
);
	`S6U_ASSERT(a_no_back_to_back, clk, arst_n, strobe |=> !strobe, "strobes back to back")
	`S6U_ASSERT(a_zp_code, clk, arst_n, strobe |-> (zero_point == 6'd0 || zero_point == 6'd32), "bad zero point")
	`S6U_ASSERT(a_last_idx, clk, arst_n, strobe |-> (last_chunk == (chunk_index == 5'd31)), "last flag mismatch")
	`S6U_ASSERT(a_take_quiet, clk, arst_n, (start && !busy) |=> !strobe, "result right after intake")
	`S6U_ASSERT(a_next_idx, clk, arst_n, (strobe && !last_chunk) |=> !strobe ##1 !strobe, "chunk too fast")
endmodule

bind six_bit_superblock_unpack_unit s6u_checker u_s6u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.strobe      (strobe),
	.zero_point  (zero_point),
	.chunk_index (chunk_index),
	.last_chunk  (last_chunk)
);
`default_nettype wire
